// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int DATA_W = 16;
	localparam int BR_W = 2;

	localparam logic [BR_W-1:0] BR_TRACE = 2'd0;
	localparam logic [BR_W-1:0] BR_R00 = 2'd1;
	localparam logic [BR_W-1:0] BR_R11 = 2'd2;
	localparam logic [BR_W-1:0] BR_R22 = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic [BR_W-1:0] branch_taken;
		logic invalid;
	} res_t;

endpackage

// ===== rtl/rmq_req_if.sv =====
interface rmq_req_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] r00;
	logic signed [DATA_W-1:0] r01;
	logic signed [DATA_W-1:0] r02;
	logic signed [DATA_W-1:0] r10;
	logic signed [DATA_W-1:0] r11;
	logic signed [DATA_W-1:0] r12;
	logic signed [DATA_W-1:0] r20;
	logic signed [DATA_W-1:0] r21;
	logic signed [DATA_W-1:0] r22;

	modport source(output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
	modport sink(input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

// ===== rtl/rmq_res_if.sv =====
interface rmq_res_if import rmq_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] quat_w;
	logic signed [DATA_W-1:0] quat_x;
	logic signed [DATA_W-1:0] quat_y;
	logic signed [DATA_W-1:0] quat_z;
	logic [BR_W-1:0] branch_taken;
	logic invalid;

	modport source(output valid, quat_w, quat_x, quat_y, quat_z, branch_taken, invalid,
		input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, branch_taken, invalid,
		output ready);
endinterface

// ===== rtl/rmq_sqrt_pipe.sv =====
module rmq_sqrt_pipe #(
	parameter int RW = 32,
	parameter int MW = RW / 2
) (
	input logic clk,
	input logic en,
	input logic [RW-1:0] rad,
	output logic [MW-1:0] root
);

	logic [MW+1:0] rem_q [MW];
	logic [MW-1:0] root_q [MW];
	logic [RW-1:0] rest_q [MW];

	for (genvar i = 0; i < MW; i++) begin : g_step
		logic [MW+1:0] rem_p;
		logic [MW-1:0] root_p;
		logic [RW-1:0] rest_p;
		logic [MW+1:0] cur;
		logic [MW+1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign root_p = '0;
			assign rest_p = rad;
		end else begin : g_next
			assign rem_p = rem_q[i-1];
			assign root_p = root_q[i-1];
			assign rest_p = rest_q[i-1];
		end

		always_comb begin
			cur = {rem_p[MW-1:0], rest_p[RW-1 -: 2]};
			trial = {root_p, 2'b01};
			ge = cur >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? cur - trial : cur;
				root_q[i] <= {root_p[MW-2:0], ge};
				rest_q[i] <= {rest_p[RW-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[MW-1];

endmodule

// ===== rtl/rmq_div_pipe.sv =====
module rmq_div_pipe #(
	parameter int NW = 31,
	parameter int DW = 18
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] num,
	input logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_q [NW];
	logic [NW-1:0] quo_q [NW];
	logic [NW-1:0] num_q [NW];
	logic [DW-1:0] den_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_step
		logic [DW-1:0] rem_p;
		logic [NW-1:0] quo_p;
		logic [NW-1:0] num_p;
		logic [DW-1:0] den_p;
		logic [DW:0] cur;
		logic [DW:0] diff;
		logic ge;

		if (i == 0) begin : g_first
			assign rem_p = '0;
			assign quo_p = '0;
			assign num_p = num;
			assign den_p = den;
		end else begin : g_next
			assign rem_p = rem_q[i-1];
			assign quo_p = quo_q[i-1];
			assign num_p = num_q[i-1];
			assign den_p = den_q[i-1];
		end

		always_comb begin
			cur = {rem_p, num_p[NW-1]};
			diff = cur - {1'b0, den_p};
			ge = cur >= {1'b0, den_p};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? diff[DW-1:0] : cur[DW-1:0];
				quo_q[i] <= {quo_p[NW-2:0], ge};
				num_q[i] <= {num_p[NW-2:0], 1'b0};
				den_q[i] <= den_p;
			end
		end
	end

	assign quo = quo_q[NW-1];

endmodule

// ===== rtl/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to unit quaternion by Shepperd's method, Q(FRAC_BITS) fixed point. One
// request enters per cycle unless a full output buffer that is not being read stalls it,
// with MW root bits resolved one per stage in the square-root pipeline and NW = FRAC_BITS
// + 17 quotient bits resolved one per stage in the four parallel divider pipelines.
// A two-entry output buffer lets the pipeline keep accepting while a result waits.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	rmq_req_if.sink req,
	rmq_res_if.source res
);

	localparam int ONE = 1 << FRAC_BITS;
	localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int RW0 = AW + FRAC_BITS - 2;
	localparam int RW = RW0 + (RW0 % 2);
	localparam int MW = RW / 2;
	localparam int NW = FRAC_BITS + 17;
	localparam int DW = MW + 2;
	localparam int LIM = (ONE < 32767) ? ONE : 32767;
	localparam logic signed [AW:0] ONE_A = (AW+1)'(ONE);
	localparam logic [NW-1:0] LIM_N = NW'(LIM);

	logic adv;
	logic push;
	logic pop;

	logic signed [17:0] tr;
	logic signed [AW:0] arg;
	logic [BR_W-1:0] br_a;
	logic signed [16:0] d_a [4];
	logic [RW-1:0] rad_a;

	logic v_s1;
	logic [BR_W-1:0] br_s1;
	logic bad_s1;
	logic signed [16:0] d_s1 [4];
	logic [RW-1:0] rad_s1;

	logic [MW-1:0] sq_v_q;
	logic [BR_W-1:0] sq_br_q [MW];
	logic sq_bad_q [MW];
	logic signed [16:0] sq_d_q [MW][4];
	logic [MW-1:0] root;

	logic [NW-1:0] num_b [4];
	logic [DW-1:0] den_b;

	logic v_s2;
	logic [BR_W-1:0] br_s2;
	logic bad_s2;
	logic m0_s2;
	logic [3:0] sgn_s2;
	logic [MW-1:0] m_s2;
	logic [NW-1:0] num_s2 [4];
	logic [DW-1:0] den_s2;

	logic [NW-1:0] dv_v_q;
	logic [BR_W-1:0] dv_br_q [NW];
	logic dv_bad_q [NW];
	logic dv_m0_q [NW];
	logic [3:0] dv_sgn_q [NW];
	logic [MW-1:0] dv_m_q [NW];
	logic [NW-1:0] quo [4];

	logic signed [DATA_W-1:0] part_c [4];
	logic bad_c;
	res_t res_c;

	res_t buf_q [2];
	logic [1:0] cnt_q;
	logic wr_ptr_q;
	logic rd_ptr_q;

	assign pop = res.valid && res.ready;
	assign adv = (cnt_q != 2'd2) || res.ready;
	assign req.ready = adv;

	always_comb begin
		tr = 18'(req.r00) + 18'(req.r11) + 18'(req.r22);
		for (int k = 0; k < 4; k++) begin
			d_a[k] = '0;
		end
		if (tr > 18'sd0) begin
			br_a = BR_TRACE;
			arg = ONE_A + (AW+1)'(tr);
			d_a[1] = 17'(req.r21) - 17'(req.r12);
			d_a[2] = 17'(req.r02) - 17'(req.r20);
			d_a[3] = 17'(req.r10) - 17'(req.r01);
		end else if (req.r00 > req.r11 && req.r00 > req.r22) begin
			br_a = BR_R00;
			arg = ONE_A + (AW+1)'(req.r00) - (AW+1)'(req.r11) - (AW+1)'(req.r22);
			d_a[0] = 17'(req.r21) - 17'(req.r12);
			d_a[2] = 17'(req.r01) + 17'(req.r10);
			d_a[3] = 17'(req.r02) + 17'(req.r20);
		end else if (req.r11 > req.r22) begin
			br_a = BR_R11;
			arg = ONE_A + (AW+1)'(req.r11) - (AW+1)'(req.r00) - (AW+1)'(req.r22);
			d_a[0] = 17'(req.r02) - 17'(req.r20);
			d_a[1] = 17'(req.r01) + 17'(req.r10);
			d_a[3] = 17'(req.r12) + 17'(req.r21);
		end else begin
			br_a = BR_R22;
			arg = ONE_A + (AW+1)'(req.r22) - (AW+1)'(req.r00) - (AW+1)'(req.r11);
			d_a[0] = 17'(req.r10) - 17'(req.r01);
			d_a[1] = 17'(req.r02) + 17'(req.r20);
			d_a[2] = 17'(req.r12) + 17'(req.r21);
		end
		rad_a = arg[AW] ? '0 : RW'({arg[AW-1:0], {(FRAC_BITS-2){1'b0}}});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			br_s1 <= br_a;
			bad_s1 <= arg[AW];
			d_s1 <= d_a;
			rad_s1 <= rad_a;
		end
	end

	rmq_sqrt_pipe #(.RW(RW), .MW(MW)) u_sqrt (
		.clk(clk),
		.en(adv),
		.rad(rad_s1),
		.root(root)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_br_q[0] <= br_s1;
			sq_bad_q[0] <= bad_s1;
			sq_d_q[0] <= d_s1;
			for (int i = 1; i < MW; i++) begin
				sq_br_q[i] <= sq_br_q[i-1];
				sq_bad_q[i] <= sq_bad_q[i-1];
				sq_d_q[i] <= sq_d_q[i-1];
			end
		end
	end

	always_comb begin
		logic signed [16:0] dmag;
		for (int k = 0; k < 4; k++) begin
			dmag = sq_d_q[MW-1][k][16] ? -sq_d_q[MW-1][k] : sq_d_q[MW-1][k];
			num_b[k] = NW'({dmag, {FRAC_BITS{1'b0}}}) + NW'({root, 1'b0});
		end
		den_b = {root, 2'b00};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			br_s2 <= sq_br_q[MW-1];
			bad_s2 <= sq_bad_q[MW-1] || (root == '0);
			m0_s2 <= root == '0;
			for (int k = 0; k < 4; k++) begin
				sgn_s2[k] <= sq_d_q[MW-1][k][16];
			end
			m_s2 <= root;
			num_s2 <= num_b;
			den_s2 <= den_b;
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_div
		rmq_div_pipe #(.NW(NW), .DW(DW)) u_div (
			.clk(clk),
			.en(adv),
			.num(num_s2[k]),
			.den(den_s2),
			.quo(quo[k])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_br_q[0] <= br_s2;
			dv_bad_q[0] <= bad_s2;
			dv_m0_q[0] <= m0_s2;
			dv_sgn_q[0] <= sgn_s2;
			dv_m_q[0] <= m_s2;
			for (int i = 1; i < NW; i++) begin
				dv_br_q[i] <= dv_br_q[i-1];
				dv_bad_q[i] <= dv_bad_q[i-1];
				dv_m0_q[i] <= dv_m0_q[i-1];
				dv_sgn_q[i] <= dv_sgn_q[i-1];
				dv_m_q[i] <= dv_m_q[i-1];
			end
		end
	end

	always_comb begin
		logic [NW-1:0] val;
		logic [DATA_W-1:0] magn;
		logic main;
		bad_c = dv_bad_q[NW-1];
		for (int k = 0; k < 4; k++) begin
			main = dv_br_q[NW-1] == BR_W'(k);
			if (main) begin
				val = NW'(dv_m_q[NW-1]);
			end else if (dv_m0_q[NW-1]) begin
				val = '0;
			end else begin
				val = quo[k];
			end
			if (val > LIM_N) begin
				magn = DATA_W'(LIM);
				bad_c = 1'b1;
			end else begin
				magn = val[DATA_W-1:0];
			end
			part_c[k] = (!main && dv_sgn_q[NW-1][k]) ? -$signed(magn) : $signed(magn);
		end
		res_c.quat_w = part_c[0];
		res_c.quat_x = part_c[1];
		res_c.quat_y = part_c[2];
		res_c.quat_z = part_c[3];
		res_c.branch_taken = dv_br_q[NW-1];
		res_c.invalid = bad_c;
	end

	assign push = adv && dv_v_q[NW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sq_v_q <= '0;
			v_s2 <= 1'b0;
			dv_v_q <= '0;
		end else if (adv) begin
			v_s1 <= req.valid;
			sq_v_q <= {sq_v_q[MW-2:0], v_s1};
			v_s2 <= sq_v_q[MW-1];
			dv_v_q <= {dv_v_q[NW-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
		end
	end

	assign res.valid = cnt_q != 2'd0;
	assign res.quat_w = buf_q[rd_ptr_q].quat_w;
	assign res.quat_x = buf_q[rd_ptr_q].quat_x;
	assign res.quat_y = buf_q[rd_ptr_q].quat_y;
	assign res.quat_z = buf_q[rd_ptr_q].quat_z;
	assign res.branch_taken = buf_q[rd_ptr_q].branch_taken;
	assign res.invalid = buf_q[rd_ptr_q].invalid;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && cnt_q == 2'd2))
		else $error("output buffer overflow");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(dv_v_q))
		else $error("pipeline moved during stall");

endmodule
